// ===== sv/jfphs_pkg.sv =====
// ----------------------------------------------------------------------------
// jfphs_pkg
// Shared types and constants for the five-point Jacobi heat sweep core:
// transaction payloads, action and register codes, fixed-point constants.
// ----------------------------------------------------------------------------
package jfphs_pkg;

    // grid geometry default and field widths
    localparam int MAX_SIDE_DEF = 64;
    localparam int CELL_W       = 24;
    localparam int SIDE_CFG_W   = 7;
    localparam int COUNT_W      = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = COUNT_W;

    // register reset values
    localparam logic [SIDE_CFG_W-1:0] SIDE_RESET  = 7'd64;
    localparam logic [COUNT_W-1:0]    COUNT_RESET = 16'd1;

    // five-point sum and floor division by five
    // sum of five cells needs 27 bits signed; an offset of five times 2^23
    // makes it non-negative, then a reciprocal multiply by ceil(2^29 / 5)
    // gives the exact quotient for every sum below 2^27
    localparam int                     SUM_W      = 27;
    localparam int                     PROD_W     = 2 * SUM_W;
    localparam int                     DIV_SHIFT  = 29;
    localparam logic signed [SUM_W-1:0] SUM_OFFSET = 27'sd41943040;
    localparam logic [SUM_W-1:0]       DIV_MAGIC  = 27'd107374183;

    // action codes of an input transaction
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_SWEEP = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIDE   = 1'b0,
        CFG_SWEEP_COUNT = 1'b1
    } t_cfg_reg;

    // input transaction
    typedef struct packed {
        logic [1:0]               action;
        logic [5:0]               row;
        logic [5:0]               col;
        logic signed [CELL_W-1:0] value;
    } t_item;

    // result transaction
    typedef struct packed {
        logic signed [CELL_W-1:0] read_value;
        logic                     done_res;
    } t_result;

endpackage

// ===== sv/jfphs_ram.sv =====
// ----------------------------------------------------------------------------
// jfphs_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module jfphs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/jacobi_five_point_heat_sweep_core.sv =====
// ----------------------------------------------------------------------------
// jacobi_five_point_heat_sweep_core
// Square grid of signed Q8.16 cells, double buffered in two memories.
// Write and read transactions touch the front grid; a sweep transaction runs
// sweep_count Jacobi iterations of the five-point mean over the active square.
//
//   channel   handshake              payload      direction
//   ------    ---------------------  -----------  ---------
//   item      start && !busy         i_item       in
//   result    o_strobe (one cycle)   o_result     out
//   config    i_cfg_we               i_cfg_idx,   in
//                                    i_cfg_data
//
// Write, read and unknown transactions keep busy low; a new one may start
// every cycle and its result strobe comes from the pending register and
// then the output register. A sweep holds busy until sweep_count passes
// over every stored cell are done: one shared read address fetches the
// five taps of a cell one per cycle, then one multiply and one write-back
// follow. Cells outside the active square take only read, drain and copy.
// Reset is synchronous and clears control state only; grid contents are
// undefined until written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module jacobi_five_point_heat_sweep_core
    import jfphs_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_item                 i_item,
    output logic                  o_strobe,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CW    = (SW > SIDE_CFG_W) ? SW : SIDE_CFG_W;
    localparam int EW    = AW + 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP,
        S_DRAIN,
        S_MUL,
        S_WB
    } t_state;

    typedef enum logic [2:0] {
        TAP_C,
        TAP_N,
        TAP_S,
        TAP_W,
        TAP_E
    } t_tap;

    // control and datapath registers
    t_state                  r_state, n_state;
    t_tap                    r_tap, n_tap;
    logic                    r_front_sel, n_front_sel;
    logic [SIDE_CFG_W-1:0]   r_grid_side, n_grid_side;
    logic [COUNT_W-1:0]      r_sweep_count, n_sweep_count;
    logic [COUNT_W-1:0]      r_iter, n_iter;
    logic [SW-1:0]           r_side, n_side;
    logic [RW-1:0]           r_row, n_row;
    logic [RW-1:0]           r_col, n_col;
    logic [AW-1:0]           r_addr, n_addr;
    logic                    r_pend, n_pend;
    logic                    r_first, n_first;
    logic signed [SUM_W-1:0] r_acc, n_acc;
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic                    r_p_valid, n_p_valid;
    logic                    r_p_isread, n_p_isread;
    logic                    r_p_inrange, n_p_inrange;
    logic                    r_p_done, n_p_done;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out_res, n_out_res;

    // memory ports
    logic                     we0, we1;
    logic [AW-1:0]            waddr, raddr;
    logic [CELL_W-1:0]        wdata;
    logic [CELL_W-1:0]        rdata0, rdata1;
    logic signed [CELL_W-1:0] src_rdata;

    // helpers
    logic              accept;
    logic              item_in_range;
    logic [EW-1:0]     item_addr_wide;
    logic [AW-1:0]     item_addr;
    logic [AW-1:0]     tap_addr;
    logic              cell_active;
    logic              row_top, row_bot, col_lft, col_rgt;
    logic [CW-1:0]     side_ext;
    logic [CW-1:0]     side_clamp;
    logic [SUM_W-1:0]  sum_biased;
    logic [CELL_W-1:0] quot;
    logic [CELL_W-1:0] wb_value;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // cell address of a write or read transaction
    assign item_in_range  = (EW'(i_item.row) < EW'(MAX_SIDE))
                         && (EW'(i_item.col) < EW'(MAX_SIDE));
    assign item_addr_wide = EW'(i_item.row) * EW'(MAX_SIDE) + EW'(i_item.col);
    assign item_addr      = item_addr_wide[AW-1:0];

    // position of the current cell within the active square
    assign cell_active = (SW'(r_row) < r_side) && (SW'(r_col) < r_side);
    assign row_top     = (r_row == '0);
    assign row_bot     = ((SW'(r_row) + SW'(1)) == r_side);
    assign col_lft     = (r_col == '0);
    assign col_rgt     = ((SW'(r_col) + SW'(1)) == r_side);

    // neighbour address; an edge neighbour falls back to the cell itself
    always_comb begin
        case (r_tap)
            TAP_C:   tap_addr = r_addr;
            TAP_N:   tap_addr = row_top ? r_addr : r_addr - AW'(MAX_SIDE);
            TAP_S:   tap_addr = row_bot ? r_addr : r_addr + AW'(MAX_SIDE);
            TAP_W:   tap_addr = col_lft ? r_addr : r_addr - AW'(1);
            TAP_E:   tap_addr = col_rgt ? r_addr : r_addr + AW'(1);
            default: tap_addr = r_addr;
        endcase
    end

    // side clamped to the storage range
    always_comb begin
        side_ext = CW'(r_grid_side);
        if (side_ext < CW'(2)) begin
            side_clamp = CW'(2);
        end else if (side_ext > CW'(MAX_SIDE)) begin
            side_clamp = CW'(MAX_SIDE);
        end else begin
            side_clamp = side_ext;
        end
    end

    // floor division by five: bias, reciprocal multiply, unbias
    assign sum_biased = r_acc + SUM_OFFSET;
    assign quot       = r_prod[DIV_SHIFT +: CELL_W];
    assign wb_value   = cell_active ? {~quot[CELL_W-1], quot[CELL_W-2:0]}
                                    : r_acc[CELL_W-1:0];

    // read data of the front (source) grid
    assign src_rdata = r_front_sel ? rdata1 : rdata0;

    // next-state logic
    always_comb begin
        n_state       = r_state;
        n_tap         = r_tap;
        n_front_sel   = r_front_sel;
        n_grid_side   = r_grid_side;
        n_sweep_count = r_sweep_count;
        n_iter        = r_iter;
        n_side        = r_side;
        n_row         = r_row;
        n_col         = r_col;
        n_addr        = r_addr;
        n_acc         = r_acc;
        n_prod        = r_prod;
        n_pend        = 1'b0;
        n_first       = r_first;
        n_p_valid     = 1'b0;
        n_p_isread    = 1'b0;
        n_p_inrange   = item_in_range;
        n_p_done      = 1'b0;
        we0           = 1'b0;
        we1           = 1'b0;
        waddr         = r_addr;
        wdata         = wb_value;
        raddr         = tap_addr;

        // result stage: read data arrives in the cycle after the request
        n_out_valid          = r_p_valid;
        n_out_res.read_value = (r_p_isread && r_p_inrange) ? src_rdata : '0;
        n_out_res.done_res   = r_p_done;

        // shared accumulator over the five taps
        if (r_pend) begin
            n_acc = (r_first ? '0 : r_acc) + SUM_W'(src_rdata);
        end

        // configuration writes
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_SIDE:   n_grid_side   = i_cfg_data[SIDE_CFG_W-1:0];
                CFG_SWEEP_COUNT: n_sweep_count = i_cfg_data[COUNT_W-1:0];
                default:         n_grid_side   = r_grid_side;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                raddr = item_addr;
                waddr = item_addr;
                wdata = i_item.value;
                if (accept) begin
                    case (i_item.action)
                        ACT_WRITE: begin
                            we0       = item_in_range && !r_front_sel;
                            we1       = item_in_range && r_front_sel;
                            n_p_valid = 1'b1;
                            n_p_done  = 1'b1;
                        end
                        ACT_READ: begin
                            n_p_valid  = 1'b1;
                            n_p_isread = 1'b1;
                            n_p_done   = 1'b1;
                        end
                        ACT_SWEEP: begin
                            if (r_sweep_count == '0) begin
                                n_p_valid = 1'b1;
                                n_p_done  = 1'b1;
                            end else begin
                                n_side  = SW'(side_clamp);
                                n_row   = '0;
                                n_col   = '0;
                                n_addr  = '0;
                                n_iter  = '0;
                                n_tap   = TAP_C;
                                n_state = S_TAP;
                            end
                        end
                        default: begin
                            n_p_valid = 1'b1;
                        end
                    endcase
                end
            end

            // one neighbour read per cycle; outside cells read only the centre
            S_TAP: begin
                n_pend  = 1'b1;
                n_first = (r_tap == TAP_C);
                if (cell_active && (r_tap != TAP_E)) begin
                    n_tap = t_tap'(r_tap + 3'd1);
                end else begin
                    n_tap   = TAP_C;
                    n_state = S_DRAIN;
                end
            end

            // last tap lands in the accumulator
            S_DRAIN: begin
                n_state = cell_active ? S_MUL : S_WB;
            end

            S_MUL: begin
                n_prod  = sum_biased * DIV_MAGIC;
                n_state = S_WB;
            end

            // write the back grid and step to the next cell
            S_WB: begin
                we0    = r_front_sel;
                we1    = !r_front_sel;
                n_addr = r_addr + AW'(1);
                n_state = S_TAP;
                if (r_col == RW'(MAX_SIDE - 1)) begin
                    n_col = '0;
                    if (r_row == RW'(MAX_SIDE - 1)) begin
                        n_row       = '0;
                        n_addr      = '0;
                        n_front_sel = !r_front_sel;
                        n_iter      = r_iter + COUNT_W'(1);
                        if ((r_iter + COUNT_W'(1)) == r_sweep_count) begin
                            n_state   = S_IDLE;
                            n_p_valid = 1'b1;
                            n_p_done  = 1'b1;
                        end
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end else begin
                    n_col = r_col + RW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_tap         <= TAP_C;
            r_front_sel   <= 1'b0;
            r_grid_side   <= SIDE_RESET;
            r_sweep_count <= COUNT_RESET;
            r_pend        <= 1'b0;
            r_p_valid     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_tap         <= n_tap;
            r_front_sel   <= n_front_sel;
            r_grid_side   <= n_grid_side;
            r_sweep_count <= n_sweep_count;
            r_pend        <= n_pend;
            r_p_valid     <= n_p_valid;
            r_out_valid   <= n_out_valid;
        end
        r_iter      <= n_iter;
        r_side      <= n_side;
        r_row       <= n_row;
        r_col       <= n_col;
        r_addr      <= n_addr;
        r_first     <= n_first;
        r_acc       <= n_acc;
        r_prod      <= n_prod;
        r_p_isread  <= n_p_isread;
        r_p_inrange <= n_p_inrange;
        r_p_done    <= n_p_done;
        r_out_res   <= n_out_res;
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out_res;

    // grid memories: index 0 holds the front grid after reset
    jfphs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_grid0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata0)
    );

    jfphs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_grid1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata1)
    );

    // only one grid is written in any cycle
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we0 && we1))
        else $error("both grid memories written in one cycle");

    // buffers swap only at the write-back of a sweep
    a_swap_at_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_front_sel) |-> $past(r_state) == S_WB)
        else $error("grid swap outside write-back");

    // non-sweep transactions give their result through the pending and output registers
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.action != ACT_SWEEP)) ##1 i_rst_n |=> o_strobe)
        else $error("missing result strobe");

    // a sweep holds off new transactions until it is done
    a_sweep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> (busy && !r_p_valid))
        else $error("sweep not busy or result issued mid-sweep");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the five-point Jacobi heat sweep core. A grid model
// in the bench follows every accepted write, read, sweep and unknown
// transaction, and each result strobe is compared field by field with the
// oldest predicted reply. A square corner of the grid is preloaded first;
// reads go only to cells that were written and sweeps run only over an
// active square that lies inside the preloaded corner. Directed tests cover
// value extremes, grid corners, side clamping, zero and maximum sweep counts
// and the unknown action. Random phases with new register settings and
// random sender gaps follow.
// ----------------------------------------------------------------------------
module testbench;
    import jfphs_pkg::*;

    localparam int GRID_CELLS   = MAX_SIDE_DEF * MAX_SIDE_DEF;
    localparam int PRE_SIDE     = 24;
    localparam int QUIET_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 800;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int SETTLE       = 4;
    localparam int ITEM_W       = $bits(t_item);

    localparam logic [1:0]               ACT_UNKNOWN = 2'd3;
    localparam logic signed [CELL_W-1:0] TEMP_MAX    = 24'sh7FFFFF;
    localparam logic signed [CELL_W-1:0] TEMP_MIN    = 24'sh800000;

    // dut ports
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    t_item                 i_item     = '0;
    logic                  o_strobe;
    t_result               o_result;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // grid model, written marks and register copies
    logic signed [CELL_W-1:0] heat_cells [GRID_CELLS];
    bit                       cell_set   [GRID_CELLS];
    logic [SIDE_CFG_W-1:0]    side_q  = SIDE_RESET;
    logic [COUNT_W-1:0]       count_q = COUNT_RESET;

    // predicted replies, oldest first
    t_result cell_replies [$];
    t_result want_reply;

    int  mismatch_cnt = 0;
    int  quiet_cycles = 0;
    bit  gaps_on      = 1'b1;

    jacobi_five_point_heat_sweep_core #(
        .MAX_SIDE (MAX_SIDE_DEF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // side in use after clamping to the legal range
    function automatic int active_side();
        int s;
        s = int'(side_q);
        if (s < 2) s = 2;
        if (s > MAX_SIDE_DEF) s = MAX_SIDE_DEF;
        return s;
    endfunction

    // division by five rounded toward minus infinity
    function automatic logic signed [CELL_W-1:0] floor_fifth(int sum);
        int q;
        q = sum / 5;
        if ((sum % 5) != 0 && sum < 0) q = q - 1;
        return q[CELL_W-1:0];
    endfunction

    // one jacobi iteration; edge cells stand in for missing neighbours
    function automatic void jacobi_pass(int side);
        logic signed [CELL_W-1:0] nxt [GRID_CELLS];
        int r, c, up, dn, lf, rt, sum;
        nxt = heat_cells;
        for (r = 0; r < side; r++) begin
            for (c = 0; c < side; c++) begin
                up  = (r == 0) ? r : r - 1;
                dn  = (r == side - 1) ? r : r + 1;
                lf  = (c == 0) ? c : c - 1;
                rt  = (c == side - 1) ? c : c + 1;
                sum = int'(heat_cells[r * MAX_SIDE_DEF + c])
                    + int'(heat_cells[r * MAX_SIDE_DEF + lf])
                    + int'(heat_cells[r * MAX_SIDE_DEF + rt])
                    + int'(heat_cells[up * MAX_SIDE_DEF + c])
                    + int'(heat_cells[dn * MAX_SIDE_DEF + c]);
                nxt[r * MAX_SIDE_DEF + c] = floor_fifth(sum);
            end
        end
        heat_cells = nxt;
    endfunction

    // apply one transaction to the grid model and return its reply
    function automatic t_result heat_model_step(t_item it);
        t_result res;
        int      at;
        int      side;
        res.read_value = '0;
        res.done_res   = 1'b1;
        at = int'(it.row) * MAX_SIDE_DEF + int'(it.col);
        case (it.action)
            ACT_WRITE: begin
                heat_cells[at] = it.value;
                cell_set[at]   = 1'b1;
            end
            ACT_SWEEP: begin
                side = active_side();
                repeat (count_q) jacobi_pass(side);
            end
            ACT_READ: begin
                res.read_value = heat_cells[at];
            end
            default: begin
                res.done_res = 1'b0;
            end
        endcase
        return res;
    endfunction

    // sender gap: mostly none, some short, a few long
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // temperature with extra weight on the extremes and near zero
    function automatic logic signed [CELL_W-1:0] pick_temperature();
        int p;
        int v;
        p = $urandom_range(0, 9);
        if (p == 0) return TEMP_MAX;
        if (p == 1) return TEMP_MIN;
        if (p == 2) begin
            v = $urandom_range(0, 20);
            v = v - 10;
            return v[CELL_W-1:0];
        end
        v = $urandom;
        return v[CELL_W-1:0];
    endfunction

    // drive one transaction, wait for acceptance, record its reply
    task automatic send_item(logic [1:0] act, logic [5:0] row, logic [5:0] col,
                             logic signed [CELL_W-1:0] temp);
        t_item               it;
        t_result             reply;
        int                  gap;
        logic [ITEM_W-1:0]   junk;
        it.action = act;
        it.row    = row;
        it.col    = col;
        it.value  = temp;
        i_item = it;
        start  = 1'b1;
        do @(posedge i_clk); while (busy);
        reply = heat_model_step(it);
        cell_replies.push_back(reply);
        @(negedge i_clk);
        gap = gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            junk   = ITEM_W'({$urandom, $urandom});
            start  = 1'b0;
            i_item = junk;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // block idle: no reply outstanding and busy low
    task automatic wait_idle();
        start = 1'b0;
        while (cell_replies.size() != 0 || busy) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // register write, only called while idle
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        if (idx == CFG_GRID_SIDE) side_q = data[SIDE_CFG_W-1:0];
        else count_q = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // corner square written once so that sweeps over it see no undefined cell
    task automatic test_preload_grid();
        int r, c;
        for (r = 0; r < PRE_SIDE; r++) begin
            for (c = 0; c < PRE_SIDE; c++) begin
                send_item(ACT_WRITE, 6'(r), 6'(c), pick_temperature());
            end
        end
    endtask

    // sweep with the reset sweep count over the preloaded square
    task automatic test_reset_defaults();
        wait_idle();
        write_reg(CFG_GRID_SIDE, 16'(PRE_SIDE));
        send_item(ACT_SWEEP, 6'd0, 6'd0, 24'sd0);
        send_item(ACT_READ, 6'd0, 6'd0, 24'sd0);
        send_item(ACT_READ, 6'(PRE_SIDE - 1), 6'(PRE_SIDE - 1), 24'sd0);
    endtask

    // extreme values at the grid corners, read back
    task automatic test_cell_extremes();
        send_item(ACT_WRITE, 6'd0, 6'd0, TEMP_MAX);
        send_item(ACT_WRITE, 6'd63, 6'd63, TEMP_MIN);
        send_item(ACT_WRITE, 6'd0, 6'd63, -24'sd1);
        send_item(ACT_WRITE, 6'd63, 6'd0, 24'sd0);
        send_item(ACT_READ, 6'd0, 6'd0, 24'sd0);
        send_item(ACT_READ, 6'd63, 6'd63, 24'sd0);
        send_item(ACT_READ, 6'd0, 6'd63, 24'sd0);
        send_item(ACT_READ, 6'd63, 6'd0, 24'sd0);
    endtask

    // unknown action must leave the cell alone
    task automatic test_unknown_action();
        send_item(ACT_UNKNOWN, 6'd10, 6'd20, TEMP_MAX);
        send_item(ACT_READ, 6'd10, 6'd20, 24'sd0);
    endtask

    // sweep with a count of zero changes nothing
    task automatic test_zero_count();
        wait_idle();
        write_reg(CFG_SWEEP_COUNT, 16'd0);
        send_item(ACT_SWEEP, 6'd0, 6'd0, 24'sd0);
        send_item(ACT_READ, 6'd0, 6'd0, 24'sd0);
        wait_idle();
        write_reg(CFG_SWEEP_COUNT, 16'd1);
    endtask

    // side below two, then several iterations at two
    task automatic test_side_clamp();
        wait_idle();
        write_reg(CFG_GRID_SIDE, 16'd0);
        send_item(ACT_SWEEP, 6'd0, 6'd0, 24'sd0);
        send_item(ACT_READ, 6'd0, 6'd0, 24'sd0);
        wait_idle();
        write_reg(CFG_GRID_SIDE, 16'd1);
        send_item(ACT_SWEEP, 6'd0, 6'd0, 24'sd0);
        send_item(ACT_READ, 6'd1, 6'd0, 24'sd0);
        wait_idle();
        write_reg(CFG_GRID_SIDE, 16'd2);
        write_reg(CFG_SWEEP_COUNT, 16'd3);
        send_item(ACT_SWEEP, 6'd0, 6'd0, 24'sd0);
        send_item(ACT_READ, 6'd1, 6'd1, 24'sd0);
        // cell outside the active square is carried over
        send_item(ACT_READ, 6'd5, 6'd5, 24'sd0);
    endtask

    // largest sweep count held while only cells are touched
    task automatic test_count_extreme();
        wait_idle();
        write_reg(CFG_SWEEP_COUNT, 16'hFFFF);
        send_item(ACT_WRITE, 6'd31, 6'd32, TEMP_MIN);
        send_item(ACT_READ, 6'd31, 6'd32, 24'sd0);
        wait_idle();
        write_reg(CFG_SWEEP_COUNT, 16'd1);
    endtask

    // random phases, each with its own register setting
    task automatic test_random_phases();
        int                    sent;
        int                    phase_len;
        int                    n;
        int                    p;
        int                    eff;
        int                    sweeps_left;
        bit                    sweep_ok;
        logic [SIDE_CFG_W-1:0] side_raw;
        logic [8:0]            upper;
        logic [COUNT_W-1:0]    cnt;
        logic [5:0]            row, col;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            // pick the side, mostly small
            p = $urandom_range(0, 9);
            if (p == 0) side_raw = 7'($urandom_range(0, 1));
            else if (p == 1) side_raw = 7'($urandom_range(65, 127));
            else if (p == 2) side_raw = 7'd64;
            else if (p < 5) side_raw = 7'($urandom_range(9, 63));
            else side_raw = 7'($urandom_range(2, 8));
            upper = 9'($urandom);
            write_reg(CFG_GRID_SIDE, {upper, side_raw});
            eff = active_side();
            // pick the count; large counts come with no sweeps at all
            p = $urandom_range(0, 9);
            if (p == 0) cnt = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(3, 65534));
            else if (p < 3) cnt = 16'd0;
            else if (p < 5) cnt = (eff <= 32) ? 16'd2 : 16'd1;
            else cnt = 16'd1;
            write_reg(CFG_SWEEP_COUNT, cnt);
            // sweeps only over a square that was written in full
            sweep_ok    = (cnt <= 16'd2) && (eff <= PRE_SIDE);
            sweeps_left = 2;
            gaps_on     = ($urandom_range(0, 3) != 0);
            phase_len   = $urandom_range(80, 160);
            for (n = 0; n < phase_len; n++) begin
                // half the cell accesses land inside the active square
                if ($urandom_range(0, 1)) begin
                    row = 6'($urandom_range(0, eff - 1));
                    col = 6'($urandom_range(0, eff - 1));
                end else begin
                    row = 6'($urandom);
                    col = 6'($urandom);
                end
                p = $urandom_range(0, 99);
                if (p < 2 && sweep_ok && sweeps_left > 0) begin
                    sweeps_left--;
                    send_item(ACT_SWEEP, row, col, pick_temperature());
                end else if (p < 6) begin
                    send_item(ACT_UNKNOWN, row, col, pick_temperature());
                end else if (p < 53) begin
                    send_item(ACT_WRITE, row, col, pick_temperature());
                end else begin
                    // reads only go to cells that hold a written value
                    if (!cell_set[int'(row) * MAX_SIDE_DEF + int'(col)]) begin
                        row = 6'($urandom_range(0, PRE_SIDE - 1));
                        col = 6'($urandom_range(0, PRE_SIDE - 1));
                    end
                    send_item(ACT_READ, row, col, pick_temperature());
                end
            end
            sent += phase_len;
        end
        gaps_on = 1'b1;
    endtask

    // compare each result strobe with the oldest predicted reply
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (cell_replies.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result: read_value %0d done_res %0b",
                             o_result.read_value, o_result.done_res);
            end else begin
                want_reply = cell_replies.pop_front();
                if (o_result.read_value !== want_reply.read_value ||
                    o_result.done_res !== want_reply.done_res) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display({"mismatch: expected read_value %0d done_res %0b,",
                                  " got read_value %0d done_res %0b"},
                                 want_reply.read_value, want_reply.done_res,
                                 o_result.read_value, o_result.done_res);
                end
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_strobe) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("testbench failed");
        $finish;
    end

    // test sequence
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_preload_grid();
        test_reset_defaults();
        test_cell_extremes();
        test_unknown_action();
        test_zero_count();
        test_side_clamp();
        test_count_extreme();
        test_random_phases();
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
